### rtl/core/slp_pkg.sv
// Package for the serial link port: command codes, register indexes,
// constants and the request/result structs. No dependencies.
package slp_pkg;

  // Commands carried by one request.
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_RD_DATA  = 3'd1,
    CMD_WR_DATA  = 3'd2,
    CMD_RD_CTRL  = 3'd3,
    CMD_WR_CTRL  = 3'd4,
    CMD_EXCHANGE = 3'd5
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_COLOR_MODE   = 1'b0,
    CFG_DOUBLE_SPEED = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  localparam logic [7:0]  ForceColor    = 8'h7C;
  localparam logic [7:0]  ForceMono     = 8'h7E;
  localparam logic [9:0]  BasePeriod    = 10'd512;
  localparam logic [2:0]  FastShift     = 3'd5;
  localparam logic [7:0]  NoPartnerByte = 8'hFF;
  localparam logic [15:0] AccumMax      = 16'hFFFF;
  localparam logic [2:0]  LastBit       = 3'd7;

  // Control register bits.
  localparam int unsigned CtrlActive   = 7;
  localparam int unsigned CtrlFast     = 1;
  localparam int unsigned CtrlInternal = 0;

  // One request as held in the input register.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] cycles;
    logic [7:0] wdata;
    logic       partner_connected;
    logic [7:0] partner_byte;
  } req_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [7:0] read_data;
    logic       transfer_done;
  } rsp_t;

  // Configuration bits seen by the execution stage.
  typedef struct packed {
    logic color_mode;
    logic double_speed;
  } cfg_t;

endpackage

### rtl/core/slp_if.sv
// Request and result channel interfaces of the serial link port.
// Depends on slp_pkg for nothing but is compiled after it.
interface slp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] cycles;
  logic [7:0] wdata;
  logic       partner_connected;
  logic [7:0] partner_byte;

  modport source (output valid, cmd, cycles, wdata, partner_connected, partner_byte,
                  input ready);
  modport sink   (input valid, cmd, cycles, wdata, partner_connected, partner_byte,
                  output ready);
endinterface

interface slp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       transfer_done;

  modport source (output valid, read_data, transfer_done, input ready);
  modport sink   (input valid, read_data, transfer_done, output ready);
endinterface

### rtl/core/slp_cfg.sv
// Configuration registers of the serial link port (color mode, double speed).
// Depends on slp_pkg.
module slp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [slp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [slp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output slp_pkg::cfg_t                cfg_o
);

  logic color_q, color_d;
  logic speed_q, speed_d;

  // Decode the register index of a write.
  always_comb begin
    color_d = color_q;
    speed_d = speed_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slp_pkg::CFG_COLOR_MODE:   color_d = cfg_wdata_i[0];
        slp_pkg::CFG_DOUBLE_SPEED: speed_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b0;
      speed_q <= 1'b0;
    end else begin
      color_q <= color_d;
      speed_q <= speed_d;
    end
  end

  assign cfg_o.color_mode   = color_q;
  assign cfg_o.double_speed = speed_q;

endmodule

### rtl/core/slp_exec.sv
// Execution stage of the serial link port: port state registers and the
// combinational update for one request. Depends on slp_pkg.
module slp_exec (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  slp_pkg::req_t  req_i,
  input  slp_pkg::cfg_t  cfg_i,
  output slp_pkg::rsp_t  rsp_o
);

  logic [7:0]  data_q, data_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [15:0] accum_q, accum_d;
  logic [2:0]  bits_q, bits_d;

  logic [2:0]  shift;
  logic [9:0]  period;
  logic [16:0] sum_wide;
  logic [15:0] sum_sat;
  logic        bit_due;
  logic [7:0]  pattern;

  // Bit period and saturating accumulator sum for a tick.
  always_comb begin
    shift    = (ctrl_q[slp_pkg::CtrlFast] ? slp_pkg::FastShift : 3'd0)
             + {2'b00, cfg_i.double_speed};
    period   = slp_pkg::BasePeriod >> shift;
    sum_wide = {1'b0, accum_q} + {9'd0, req_i.cycles};
    sum_sat  = sum_wide[16] ? slp_pkg::AccumMax : sum_wide[15:0];
    bit_due  = sum_sat >= {6'd0, period};
    pattern  = cfg_i.color_mode ? slp_pkg::ForceColor : slp_pkg::ForceMono;
  end

  // Next state and result for the request in the input register.
  always_comb begin
    data_d              = data_q;
    ctrl_d              = ctrl_q;
    accum_d             = accum_q;
    bits_d              = bits_q;
    rsp_o.read_data     = 8'd0;
    rsp_o.transfer_done = 1'b0;
    unique case (req_i.cmd)
      slp_pkg::CMD_TICK: begin
        if (ctrl_q[slp_pkg::CtrlActive] && ctrl_q[slp_pkg::CtrlInternal]) begin
          accum_d = sum_sat;
          if (bit_due) begin
            accum_d = sum_sat - {6'd0, period};
            bits_d  = bits_q + 3'd1;
            if (bits_q == slp_pkg::LastBit) begin
              data_d = req_i.partner_connected ? req_i.partner_byte
                                               : slp_pkg::NoPartnerByte;
              ctrl_d[slp_pkg::CtrlActive] = 1'b0;
              rsp_o.transfer_done         = 1'b1;
            end
          end
        end
      end
      slp_pkg::CMD_RD_DATA:  rsp_o.read_data = data_q;
      slp_pkg::CMD_WR_DATA:  data_d = req_i.wdata;
      slp_pkg::CMD_RD_CTRL:  rsp_o.read_data = ctrl_q;
      slp_pkg::CMD_WR_CTRL:  ctrl_d = req_i.wdata | pattern;
      slp_pkg::CMD_EXCHANGE: begin
        rsp_o.read_data = data_q;
        data_d          = req_i.wdata;
      end
      default: ;
    endcase
  end

  // State commits only when the request moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q  <= 8'd0;
      ctrl_q  <= slp_pkg::ForceMono;
      accum_q <= 16'd0;
      bits_q  <= 3'd0;
    end else if (fire_i) begin
      data_q  <= data_d;
      ctrl_q  <= ctrl_d;
      accum_q <= accum_d;
      bits_q  <= bits_d;
    end
  end

endmodule

### rtl/core/serial_link_port.sv
// Top level of the serial link port: input register, execution stage and
// result register. Depends on slp_pkg, slp_in_if, slp_out_if, slp_cfg, slp_exec.
//
//   channel  | direction | handshake     | payload
//   in_i     | sink      | valid/ready   | cmd, cycles, wdata, partner_connected, partner_byte
//   out_o    | source    | valid/ready   | read_data, transfer_done
//   cfg      | sink      | cfg_we_i only | cfg_idx_i, cfg_wdata_i
//
// One request per cycle while the output is not stalled; a taken request moves from
// the input register to the result register, whose output is then valid.
// The state update between the two registers is combinational.
// Reset leaves both registers empty and the port state at its idle values.
// A stalled result holds the result register; the input register then fills,
// and ready drops only when both are occupied.
module serial_link_port (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  slp_in_if.sink                       in_i,
  slp_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [slp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [slp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic          req_vld_q;
  slp_pkg::req_t req_q;
  logic          rsp_vld_q;
  slp_pkg::rsp_t rsp_q;
  slp_pkg::rsp_t rsp_d;
  slp_pkg::cfg_t cfg;
  logic          fire;
  logic          in_take;

  // Pipeline handshake: the input request moves when the result slot frees.
  assign fire      = req_vld_q && (!rsp_vld_q || out_o.ready);
  assign in_i.ready = !req_vld_q || fire;
  assign in_take   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        req_vld_q <= 1'b1;
      end else if (fire) begin
        req_vld_q <= 1'b0;
      end
      if (fire) begin
        rsp_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.cmd               <= in_i.cmd;
      req_q.cycles            <= in_i.cycles;
      req_q.wdata             <= in_i.wdata;
      req_q.partner_connected <= in_i.partner_connected;
      req_q.partner_byte      <= in_i.partner_byte;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  slp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slp_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp_d)
  );

  assign out_o.valid         = rsp_vld_q;
  assign out_o.read_data     = rsp_q.read_data;
  assign out_o.transfer_done = rsp_q.transfer_done;

endmodule

### rtl/core/slp_checker.sv
// Port-level checker for the serial link port, bound to the top level.
// Depends on serial_link_port and its channel interfaces.
module slp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] read_data_i,
  input logic       transfer_done_i
);

  // A completed transfer comes from a tick, which never returns read data.
  a_done_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && transfer_done_i |-> read_data_i == 8'd0)
    else $error("transfer_done with nonzero read_data");

  // Requests are refused only while a result is stalled at the output.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input not ready without an output stall");

  // A result that appears into an empty slot matches a request accepted at the input.
  a_rose_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i)
      && $stable(transfer_done_i))
    else $error("stalled result changed");

endmodule

bind serial_link_port slp_checker u_slp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .read_data_i     (out_o.read_data),
  .transfer_done_i (out_o.transfer_done)
);

### bench/tb_serial_link_port.sv
// Self-checking testbench for serial_link_port: directed register, transfer and
// saturation tests plus randomized traffic with source and sink idling.
// Depends on slp_pkg, slp_in_if, slp_out_if and the serial_link_port RTL.
module tb_serial_link_port;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldLen       = 60;
  localparam int unsigned SettleCycles  = 4;

  logic clk_i;
  logic rst_ni;
  logic                         cfg_we_i;
  logic [slp_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [slp_pkg::CfgDataW-1:0] cfg_wdata_i;

  slp_in_if  in_if ();
  slp_out_if out_if ();

  serial_link_port DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the port state, advanced once per accepted request.
  logic        color_m;
  logic        dspeed_m;
  logic [7:0]  data_m;
  logic [7:0]  ctrl_m;
  logic [15:0] accum_m;
  logic [2:0]  bitcnt_m;

  slp_pkg::rsp_t expected_rsp_q[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_requests;
  int unsigned errors;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned transfers_seen;
  int unsigned clipped_ticks;

  // Clock generation.
  always #2 clk_i = ~clk_i;

  // Mismatch reporting: one line per failure.
  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  // Next port state and result for one request.
  function automatic slp_pkg::rsp_t serial_port_next(slp_pkg::req_t r);
    slp_pkg::rsp_t o;
    logic [16:0]   sum;
    logic [9:0]    period;
    logic [2:0]    shamt;
    o = '0;
    case (r.cmd)
      slp_pkg::CMD_TICK: begin
        if (ctrl_m[slp_pkg::CtrlActive] && ctrl_m[slp_pkg::CtrlInternal]) begin
          sum    = {1'b0, accum_m} + {9'd0, r.cycles};
          shamt  = (ctrl_m[slp_pkg::CtrlFast] ? slp_pkg::FastShift : 3'd0) + {2'd0, dspeed_m};
          period = slp_pkg::BasePeriod >> shamt;
          if (sum > {1'b0, slp_pkg::AccumMax}) begin
            sum = {1'b0, slp_pkg::AccumMax};
            clipped_ticks++;
          end
          if (sum >= {7'd0, period}) begin
            sum = sum - {7'd0, period};
            if (bitcnt_m == slp_pkg::LastBit) begin
              bitcnt_m                    = 3'd0;
              data_m                      = r.partner_connected ? r.partner_byte
                                                                : slp_pkg::NoPartnerByte;
              ctrl_m[slp_pkg::CtrlActive] = 1'b0;
              o.transfer_done             = 1'b1;
            end else begin
              bitcnt_m = bitcnt_m + 3'd1;
            end
          end
          accum_m = sum[15:0];
        end
      end
      slp_pkg::CMD_RD_DATA: o.read_data = data_m;
      slp_pkg::CMD_WR_DATA: data_m = r.wdata;
      slp_pkg::CMD_RD_CTRL: o.read_data = ctrl_m;
      slp_pkg::CMD_WR_CTRL:
        ctrl_m = r.wdata | (color_m ? slp_pkg::ForceColor : slp_pkg::ForceMono);
      slp_pkg::CMD_EXCHANGE: begin
        o.read_data = data_m;
        data_m      = r.wdata;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Offer one request, with random idle cycles ahead of it, and predict it on acceptance.
  task automatic send_request(slp_pkg::req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.cmd               <= r.cmd;
    in_if.cycles            <= r.cycles;
    in_if.wdata             <= r.wdata;
    in_if.partner_connected <= r.partner_connected;
    in_if.partner_byte      <= r.partner_byte;
    do @(posedge clk_i); while (!in_if.ready);
    expected_rsp_q.push_back(serial_port_next(r));
    requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic slp_pkg::req_t make_req(logic [2:0] cmd, logic [7:0] cycles,
                                             logic [7:0] wdata, logic partner,
                                             logic [7:0] pbyte);
    slp_pkg::req_t r;
    r.cmd               = cmd;
    r.cycles            = cycles;
    r.wdata             = wdata;
    r.partner_connected = partner;
    r.partner_byte      = pbyte;
    return r;
  endfunction

  function automatic slp_pkg::req_t random_req();
    return make_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
  endfunction

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write both mode registers while the port is idle.
  task automatic set_port_mode(logic color, logic dspeed);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= slp_pkg::CFG_COLOR_MODE;
    cfg_wdata_i <= color;
    @(negedge clk_i);
    cfg_idx_i   <= slp_pkg::CFG_DOUBLE_SPEED;
    cfg_wdata_i <= dspeed;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    color_m  = color;
    dspeed_m = dspeed;
    @(negedge clk_i);
  endtask

  // Reset values, data and control access, unknown commands and color pattern.
  task automatic test_register_access();
    send_request(make_req(slp_pkg::CMD_RD_DATA, 8'h00, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_RD_CTRL, 8'hFF, 8'hFF, 1'b1, 8'hFF));
    send_request(make_req(slp_pkg::CMD_WR_DATA, 8'h00, 8'hFF, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_RD_DATA, 8'h00, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_EXCHANGE, 8'h00, 8'h00, 1'b1, 8'hFF));
    send_request(make_req(slp_pkg::CMD_EXCHANGE, 8'hFF, 8'hA5, 1'b0, 8'h00));
    send_request(make_req(3'd6, 8'hFF, 8'hFF, 1'b1, 8'hFF));
    send_request(make_req(3'd7, 8'h5A, 8'h3C, 1'b1, 8'hC3));
    send_request(make_req(slp_pkg::CMD_RD_DATA, 8'h00, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_WR_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_RD_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    // A new color mode only shows up at the next control write.
    set_port_mode(1'b1, 1'b0);
    send_request(make_req(slp_pkg::CMD_RD_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_WR_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_RD_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    drain_results();
  endtask

  // One fast internal transfer with a large first tick, then an external-clock transfer.
  task automatic test_directed_transfer();
    set_port_mode(1'b0, 1'b0);
    send_request(make_req(slp_pkg::CMD_WR_CTRL, 8'h00, 8'h83, 1'b0, 8'h00));
    // The large tick counts a single bit and keeps the remainder.
    send_request(make_req(slp_pkg::CMD_TICK, 8'hFF, 8'h00, 1'b1, 8'h3C));
    repeat (7) send_request(make_req(slp_pkg::CMD_TICK, 8'h00, 8'h00, 1'b1, 8'h3C));
    send_request(make_req(slp_pkg::CMD_RD_DATA, 8'h00, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_RD_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    // External clock: ticks leave everything alone.
    send_request(make_req(slp_pkg::CMD_WR_CTRL, 8'h00, 8'h80, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_TICK, 8'hFF, 8'h00, 1'b0, 8'h00));
    send_request(make_req(slp_pkg::CMD_RD_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    drain_results();
  endtask

  // A well-formed transfer with random content and some interleaved accesses.
  task automatic run_transfer_burst();
    slp_pkg::req_t r;
    int            n;
    r = random_req();
    r.cmd   = slp_pkg::CMD_WR_CTRL;
    r.wdata[slp_pkg::CtrlActive] = 1'b1;
    if ($urandom_range(0, 9) != 0) r.wdata[slp_pkg::CtrlInternal] = 1'b1;
    send_request(r);
    n = 0;
    while (ctrl_m[slp_pkg::CtrlActive] && n < 64) begin
      r = random_req();
      case ($urandom_range(0, 19))
        0, 1:    r.cmd = slp_pkg::CMD_RD_CTRL;
        2:       r.cmd = slp_pkg::CMD_RD_DATA;
        3:       r.cmd = slp_pkg::CMD_EXCHANGE;
        4:       r.cmd = slp_pkg::CMD_WR_DATA;
        default: begin
          r.cmd = slp_pkg::CMD_TICK;
          if ($urandom_range(0, 3) == 0) r.cycles = 8'($urandom_range(0, 20));
        end
      endcase
      send_request(r);
      n++;
    end
    send_request(make_req(slp_pkg::CMD_RD_DATA, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255))));
  endtask

  // Random traffic in two halves with their own mode settings; optional sink hold-off.
  task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                     logic [1:0] mode_a, logic [1:0] mode_b,
                                     bit with_hold, int unsigned quota);
    int unsigned stop_at;
    for (int half = 0; half < 2; half++) begin
      set_port_mode(half == 0 ? mode_a[1] : mode_b[1], half == 0 ? mode_a[0] : mode_b[0]);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      if (with_hold && half == 0) hold_requests++;
      stop_at = requests_sent + quota / 2;
      while (requests_sent < stop_at) begin
        if ($urandom_range(0, 9) < 7) run_transfer_burst();
        else send_request(random_req());
      end
      drain_results();
    end
  endtask

  // Fastest bit period with full-size ticks until the accumulator clips repeatedly.
  task automatic test_accum_saturation();
    slp_pkg::req_t r;
    int            rounds;
    set_port_mode(1'b0, 1'b1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    rounds = 0;
    while (clipped_ticks < 12 && rounds < 80) begin
      r = random_req();
      r.cmd = slp_pkg::CMD_WR_CTRL;
      r.wdata[slp_pkg::CtrlActive]   = 1'b1;
      r.wdata[slp_pkg::CtrlFast]     = 1'b1;
      r.wdata[slp_pkg::CtrlInternal] = 1'b1;
      send_request(r);
      repeat (8) begin
        r = random_req();
        r.cmd    = slp_pkg::CMD_TICK;
        r.cycles = 8'($urandom_range(230, 255));
        send_request(r);
      end
      rounds++;
    end
    send_request(make_req(slp_pkg::CMD_RD_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
    drain_results();
  endtask

  // Sink ready: random idling, or a long hold-off when a test asks for one.
  always @(negedge clk_i) begin
    static int unsigned holds_served = 0;
    static int unsigned hold_left    = 0;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    slp_pkg::rsp_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        flag_mismatch("unexpected result", 32'(out_if.read_data), 0);
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_if.read_data !== want.read_data)
          flag_mismatch("read_data", 32'(out_if.read_data), 32'(want.read_data));
        if (out_if.transfer_done !== want.transfer_done)
          flag_mismatch("transfer_done", 32'(out_if.transfer_done),
                        32'(want.transfer_done));
        if (want.transfer_done) transfers_seen++;
      end
      results_seen++;
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  always @(posedge clk_i) begin
    static int unsigned quiet_cycles = 0;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d results outstanding.", expected_rsp_q.size());
        $display("** serial_link_port: FAILED **");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    clk_i                   = 1'b0;
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = slp_pkg::CFG_COLOR_MODE;
    cfg_wdata_i             = '0;
    in_if.valid             = 1'b0;
    in_if.cmd               = slp_pkg::CMD_TICK;
    in_if.cycles            = '0;
    in_if.wdata             = '0;
    in_if.partner_connected = 1'b0;
    in_if.partner_byte      = '0;
    out_if.ready            = 1'b0;
    src_idle_pct            = 0;
    sink_idle_pct           = 0;
    hold_requests           = 0;
    errors                  = 0;
    requests_sent           = 0;
    results_seen            = 0;
    transfers_seen          = 0;
    clipped_ticks           = 0;
    color_m                 = 1'b0;
    dspeed_m                = 1'b0;
    data_m                  = 8'h00;
    ctrl_m                  = slp_pkg::ForceMono;
    accum_m                 = 16'h0000;
    bitcnt_m                = 3'd0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 9;
    sink_idle_pct = 88;
    test_register_access();
    test_directed_transfer();
    test_random_traffic(9, 88, 2'b00, 2'b11, 1'b0, 60);
    test_random_traffic(88, 9, 2'b10, 2'b01, 1'b0, 60);
    test_random_traffic(0, 0, 2'b01, 2'b10, 1'b1, 60);
    test_accum_saturation();

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results, %0d of them completed transfers.",
             requests_sent, results_seen, transfers_seen);
    $display("Accumulator clipped on %0d ticks; %0d mismatches.", clipped_ticks, errors);
    if (errors == 0) begin
      $display("** serial_link_port: PASSED **");
    end else begin
      $display("** serial_link_port: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/slp_pkg.sv
rtl/core/slp_if.sv
rtl/core/slp_cfg.sv
rtl/core/slp_exec.sv
rtl/core/serial_link_port.sv
rtl/core/slp_checker.sv
bench/tb_serial_link_port.sv
